FILE: rtl/core/sts_pkg.sv
`default_nettype none

package sts_pkg;

   localparam int INDEX_W             = 10;
   localparam int VALUE_W             = 32;
   localparam int POINT_W             = 11;
   localparam int DEFAULT_TABLE_DEPTH = 1024;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic [POINT_W-1:0] point_index;
      logic               range_error;
   } sts_result_type;

   function automatic logic [POINT_W-1:0] to_point(input logic [INDEX_W-1:0] idx);
      return {{(POINT_W-INDEX_W){1'b0}}, idx};
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sts_table.sv
`default_nettype none

module sts_table
   import sts_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_en,
   input  wire logic [INDEX_W-1:0] wr_idx,
   input  wire logic [VALUE_W-1:0] wr_data,
   input  wire logic               rd_en,
   input  wire logic [INDEX_W-1:0] rd_idx,
   output      logic [VALUE_W-1:0] rd_data
);

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int EXT_W  = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;

   logic [VALUE_W-1:0] mem_ff [0:TABLE_DEPTH-1];
   logic [VALUE_W-1:0] rd_data_ff;
   logic               rd_ok_ff;
   logic               rd_ok_in;
   logic [EXT_W-1:0]   wr_ext;
   logic [EXT_W-1:0]   rd_ext;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic               wr_ok;

   assign wr_ext   = EXT_W'(wr_idx);
   assign rd_ext   = EXT_W'(rd_idx);
   assign wr_addr  = wr_ext[ADDR_W-1:0];
   assign rd_addr  = rd_ext[ADDR_W-1:0];
   assign wr_ok    = 32'(wr_idx) < 32'(TABLE_DEPTH);
   assign rd_ok_in = 32'(rd_idx) < 32'(TABLE_DEPTH);

   always_ff @(posedge clock) begin
      if (wr_en && wr_ok) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ok_ff <= 1'b0;
      end else if (rd_en) begin
         rd_ok_ff <= rd_ok_in;
      end
   end

   // entries beyond the table read as zero
   assign rd_data = rd_ok_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

FILE: rtl/core/sts_search.sv
`default_nettype none

module sts_search
   import sts_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               go,
   input  wire logic [VALUE_W-1:0] query_distance,
   input  wire logic [INDEX_W-1:0] start_index,
   input  wire logic [INDEX_W-1:0] end_index,
   input  wire logic [VALUE_W-1:0] rd_data,
   output      logic               rd_en,
   output      logic [INDEX_W-1:0] rd_idx,
   output      logic               idle,
   output      logic               done,
   input  wire logic               take,
   output      sts_result_type     result
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMP_LO,
      ST_CMP_HI,
      ST_CMP_MID,
      ST_STEP,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [VALUE_W-1:0] dist_ff, dist_in;
   logic [INDEX_W-1:0] lo_ff, lo_in;
   logic [INDEX_W-1:0] hi_ff, hi_in;
   sts_result_type     result_ff, result_in;
   logic [INDEX_W-1:0] span;
   logic [INDEX_W-1:0] mid;
   logic               narrow;

   assign span   = hi_ff - lo_ff;
   assign mid    = lo_ff + (span >> 1);
   assign narrow = span <= INDEX_W'(1);

   always_comb begin
      state_in  = state_ff;
      dist_in   = dist_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      result_in = result_ff;
      rd_en     = 1'b0;
      rd_idx    = start_index;
      unique case (state_ff)
         ST_IDLE: begin
            if (go) begin
               dist_in = query_distance;
               lo_in   = start_index;
               hi_in   = end_index;
               if (start_index > end_index) begin
                  result_in.point_index = '0;
                  result_in.range_error = 1'b1;
                  state_in              = ST_DONE;
               end else begin
                  rd_en    = 1'b1;
                  rd_idx   = start_index;
                  state_in = ST_CMP_LO;
               end
            end
         end
         ST_CMP_LO: begin
            // below the span
            if (dist_ff < rd_data) begin
               result_in.point_index = to_point(lo_ff) - POINT_W'(1);
               result_in.range_error = 1'b0;
               state_in              = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_idx   = hi_ff;
               state_in = ST_CMP_HI;
            end
         end
         ST_CMP_HI: begin
            if (dist_ff >= rd_data) begin
               result_in.point_index = to_point(hi_ff);
               result_in.range_error = 1'b0;
               state_in              = ST_DONE;
            end else if (narrow) begin
               result_in.point_index = to_point(lo_ff);
               result_in.range_error = 1'b0;
               state_in              = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_idx   = mid;
               state_in = ST_CMP_MID;
            end
         end
         ST_CMP_MID: begin
            if (dist_ff < rd_data) begin
               hi_in    = mid;
               state_in = ST_STEP;
            end else if (dist_ff > rd_data) begin
               lo_in    = mid;
               state_in = ST_STEP;
            end else begin
               result_in.point_index = to_point(mid);
               result_in.range_error = 1'b0;
               state_in              = ST_DONE;
            end
         end
         ST_STEP: begin
            if (narrow) begin
               result_in.point_index = to_point(lo_ff);
               result_in.range_error = 1'b0;
               state_in              = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_idx   = mid;
               state_in = ST_CMP_MID;
            end
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      dist_ff   <= dist_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      result_ff <= result_in;
   end

   assign idle   = state_ff == ST_IDLE;
   assign done   = state_ff == ST_DONE;
   assign result = result_ff;

endmodule

`default_nettype wire

FILE: rtl/core/sorted_table_interval_search.sv
// Interval lookup over a table of nondecreasing Q16.16 cumulative distances.
// Request channel (req_*): a load (req_kind = 0) writes req_entry_value to
// entry req_entry_index and gives no response; a query (req_kind = 1) locates
// req_query_distance between req_start_index and req_end_index and gives one
// response on the rsp_* channel.
// A query reads and compares the two span ends, then halves the span with one
// table read and one compare per step until it is narrow or an entry matches.
// A reversed span answers with rsp_range_error set and reads no entry.
// Only one query is in flight; req_ready is low while it is searched, so the
// next request is taken only once the response has been registered.
// The response sits in an output register; the next request is taken while it
// waits, and a finished query holds in the search unit until rsp_ready frees
// the register.
// Reset clears control state only; table contents are undefined until loaded.
`default_nettype none

module sorted_table_interval_search
   import sts_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output      logic                      req_ready,
   input  wire logic                      req_kind,
   input  wire logic [INDEX_W-1:0]        req_entry_index,
   input  wire logic [VALUE_W-1:0]        req_entry_value,
   input  wire logic [VALUE_W-1:0]        req_query_distance,
   input  wire logic [INDEX_W-1:0]        req_start_index,
   input  wire logic [INDEX_W-1:0]        req_end_index,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   output      logic signed [POINT_W-1:0] rsp_point_index,
   output      logic                      rsp_range_error
);

   logic               req_xfer;
   logic               load_go;
   logic               query_go;
   logic               rd_en;
   logic [INDEX_W-1:0] rd_idx;
   logic [VALUE_W-1:0] rd_data;
   logic               search_idle;
   logic               search_done;
   logic               take;
   sts_result_type     search_result;
   logic               rsp_valid_ff, rsp_valid_in;
   sts_result_type     rsp_ff, rsp_in;

   assign req_ready = search_idle;
   assign req_xfer  = req_valid && req_ready;
   assign load_go   = req_xfer && (req_kind == KIND_LOAD);
   assign query_go  = req_xfer && (req_kind == KIND_QUERY);
   assign take      = !rsp_valid_ff || rsp_ready;

   sts_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (load_go),
      .wr_idx  (req_entry_index),
      .wr_data (req_entry_value),
      .rd_en   (rd_en),
      .rd_idx  (rd_idx),
      .rd_data (rd_data)
   );

   sts_search u_search (
      .clock          (clock),
      .reset          (reset),
      .go             (query_go),
      .query_distance (req_query_distance),
      .start_index    (req_start_index),
      .end_index      (req_end_index),
      .rd_data        (rd_data),
      .rd_en          (rd_en),
      .rd_idx         (rd_idx),
      .idle           (search_idle),
      .done           (search_done),
      .take           (take),
      .result         (search_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (search_done && take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = search_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_index = rsp_ff.point_index;
   assign rsp_range_error = rsp_ff.range_error;

endmodule

`default_nettype wire
